// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant check failed");
`define CHT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define CHT_ASSERT_ALWAYS(lbl, expr)
`define CHT_ASSERT_IMPLY(lbl, ante, cons)
`define CHT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/cht_pkg.sv -----
// shared types and constants of the chained hash slot table
`default_nettype none
package cht_pkg;

  localparam int SLOTS   = 64;
  localparam int BUCKETS = 64;
  localparam int KEY_W   = 31;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LINK_W  = $clog2(SLOTS + 1);
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int GRP_SZ  = 8;
  localparam int GRP_W   = $clog2(GRP_SZ);
  localparam int GRPS    = SLOTS / GRP_SZ;
  localparam int GIDX_W  = SLOT_W - GRP_W;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOTS);

  // operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key_id;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  live_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic ins_wr;
    logic first;
    logic step;
    logic hit;
    logic rm_wr;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic head_nil;
    logic next_nil;
    logic match;
    logic is_remove;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cht_ram.sv -----
// generic single write, single registered read ram
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, old data on collision
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cht_ctrl.sv -----
// controller state machine sequencing insert, remove and find
`default_nettype none
`include "assert_macros.svh"
module cht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_kind,
  output logic               in_stall,
  input  wire cht_pkg::sts_t sts,
  output cht_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INS_RD = 7'b0000010,
    S_INS_WR = 7'b0000100,
    S_LOOK   = 7'b0001000,
    S_HEAD   = 7'b0010000,
    S_CMP    = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_kind) inside
            cht_pkg::KIND_INSERT:                      state_nxt = S_INS_RD;
            cht_pkg::KIND_REMOVE, cht_pkg::KIND_FIND:  state_nxt = S_LOOK;
            default:                                   state_nxt = S_FIN;
          endcase
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = !sts.full;
        state_nxt  = S_FIN;
      end
      S_LOOK: begin
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (sts.head_nil) begin
          state_nxt = S_FIN;
        end else begin
          cmd.first = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          cmd.rm_wr = sts.is_remove;
          state_nxt = S_FIN;
        end else if (sts.next_nil) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a finished transaction always returns to idle after handing off its result
  `CHT_ASSERT_NEXT(a_fin_to_idle, (state_r == S_FIN) && sts.out_free, state_r == S_IDLE)
  // a chain walk never writes and steps in the same cycle
  `CHT_ASSERT_IMPLY(a_step_excl, cmd.step, !cmd.rm_wr && !cmd.hit)
  // exactly one state is active
  `CHT_ASSERT_ALWAYS(a_state_onehot, $onehot(state_r))

endmodule
`default_nettype wire

// ----- hw/rtl/cht_dp.sv -----
// datapath: slot memories, free slot search, chain walk and result register
`default_nettype none
`include "assert_macros.svh"
module cht_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cht_pkg::in_t  in_data,
  input  wire cht_pkg::cmd_t cmd,
  output cht_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cht_pkg::out_t      out_data
);

  localparam int SLOTS   = cht_pkg::SLOTS;
  localparam int BUCKETS = cht_pkg::BUCKETS;
  localparam int SLOT_W  = cht_pkg::SLOT_W;
  localparam int LINK_W  = cht_pkg::LINK_W;
  localparam int BKT_W   = cht_pkg::BKT_W;
  localparam int KEY_W   = cht_pkg::KEY_W;
  localparam int CNT_W   = cht_pkg::CNT_W;
  localparam int GRP_SZ  = cht_pkg::GRP_SZ;
  localparam int GRP_W   = cht_pkg::GRP_W;
  localparam int GRPS    = cht_pkg::GRPS;
  localparam int GIDX_W  = cht_pkg::GIDX_W;

  // transaction payload
  logic [1:0]        kind_r;
  logic [KEY_W-1:0]  key_r;
  logic [BKT_W-1:0]  bucket;

  // chain walk
  logic [SLOT_W-1:0] cur_r;
  logic [SLOT_W-1:0] prev_r;
  logic              prev_nil_r;

  // occupancy and valid bits
  logic [SLOTS-1:0]   used_r, used_nxt;
  logic [BUCKETS-1:0] head_vld_r, head_vld_nxt;
  logic [SLOTS-1:0]   link_vld_r, link_vld_nxt;
  logic [CNT_W-1:0]   occupied_r, occupied_nxt;
  logic               hv_q_r;
  logic               lv_q_r;

  // free slot search tree
  logic [GRPS-1:0]   grp_any_r;
  logic [GRP_W-1:0]  grp_low_r [GRPS];
  logic [GRP_W-1:0]  grp_low_nxt [GRPS];
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  logic              full_r;

  // result
  logic              res_ok_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              out_valid_r;
  cht_pkg::out_t     out_data_r;

  // memory ports
  logic [LINK_W-1:0] head_rdata, link_rdata;
  logic [KEY_W-1:0]  key_rdata;
  logic [LINK_W-1:0] head_val, link_val;
  logic [SLOT_W-1:0] node_raddr;
  logic              head_we, link_we;
  logic [LINK_W-1:0] head_wdata, link_wdata;
  logic [SLOT_W-1:0] link_waddr;

  assign bucket = key_r[BKT_W-1:0];

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_data.kind;
      key_r  <= in_data.key_id;
    end
  end

  // invalid entries read as null
  assign head_val   = hv_q_r ? head_rdata : cht_pkg::NIL_LINK;
  assign link_val   = lv_q_r ? link_rdata : cht_pkg::NIL_LINK;
  assign node_raddr = cmd.step ? link_val[SLOT_W-1:0] : head_val[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    hv_q_r <= head_vld_r[bucket];
    lv_q_r <= link_vld_r[node_raddr];
  end

  // first level of the free search: lowest free slot in each group
  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      grp_low_nxt[g] = '0;
      for (int j = GRP_SZ - 1; j >= 0; j--) begin
        if (!used_r[g*GRP_SZ + j]) begin
          grp_low_nxt[g] = GRP_W'(j);
        end
      end
    end
  end

  // second level: lowest group with a free slot
  always_comb begin
    free_slot_nxt = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        free_slot_nxt = {GIDX_W'(g), grp_low_r[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GRPS; g++) begin
      grp_any_r[g] <= !(&used_r[g*GRP_SZ +: GRP_SZ]);
      grp_low_r[g] <= grp_low_nxt[g];
    end
    free_slot_r <= free_slot_nxt;
    full_r      <= !(|grp_any_r);
  end

  // chain walk position
  always_ff @(posedge clk) begin
    if (cmd.first) begin
      cur_r      <= head_val[SLOT_W-1:0];
      prev_nil_r <= 1'b1;
    end else if (cmd.step) begin
      cur_r      <= link_val[SLOT_W-1:0];
      prev_r     <= cur_r;
      prev_nil_r <= 1'b0;
    end
  end

  // memory write selection
  assign head_we    = cmd.ins_wr || (cmd.rm_wr && prev_nil_r);
  assign head_wdata = cmd.ins_wr ? LINK_W'(free_slot_r) : link_val;
  assign link_we    = cmd.ins_wr || (cmd.rm_wr && !prev_nil_r);
  assign link_waddr = cmd.ins_wr ? free_slot_r : prev_r;
  assign link_wdata = cmd.ins_wr ? head_val : link_val;

  cht_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (bucket),
    .wdata (head_wdata),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  cht_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (node_raddr),
    .rdata (link_rdata)
  );

  cht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (cmd.ins_wr),
    .waddr (free_slot_r),
    .wdata (key_r),
    .raddr (node_raddr),
    .rdata (key_rdata)
  );

  // occupancy and valid bit updates
  always_comb begin
    used_nxt     = used_r;
    head_vld_nxt = head_vld_r;
    link_vld_nxt = link_vld_r;
    occupied_nxt = occupied_r;
    if (cmd.ins_wr) begin
      used_nxt[free_slot_r]     = 1'b1;
      head_vld_nxt[bucket]      = 1'b1;
      link_vld_nxt[free_slot_r] = 1'b1;
      occupied_nxt              = occupied_r + CNT_W'(1);
    end
    if (cmd.rm_wr) begin
      used_nxt[cur_r]     = 1'b0;
      link_vld_nxt[cur_r] = 1'b0;
      if (prev_nil_r) begin
        head_vld_nxt[bucket] = 1'b1;
      end else begin
        link_vld_nxt[prev_r] = 1'b1;
      end
      occupied_nxt = occupied_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      head_vld_r <= '0;
      link_vld_r <= '0;
      occupied_r <= '0;
    end else begin
      used_r     <= used_nxt;
      head_vld_r <= head_vld_nxt;
      link_vld_r <= link_vld_nxt;
      occupied_r <= occupied_nxt;
    end
  end

  // result of the current transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok_r   <= 1'b0;
      res_slot_r <= '0;
    end else if (cmd.ins_wr) begin
      res_ok_r   <= 1'b1;
      res_slot_r <= free_slot_r;
    end else if (cmd.hit) begin
      res_ok_r   <= 1'b1;
      res_slot_r <= cur_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.ok         <= res_ok_r;
      out_data_r.slot       <= res_slot_r;
      out_data_r.live_count <= occupied_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the controller
  assign sts.full      = full_r;
  assign sts.head_nil  = (head_val == cht_pkg::NIL_LINK);
  assign sts.next_nil  = (link_val == cht_pkg::NIL_LINK);
  assign sts.match     = (key_rdata == key_r);
  assign sts.is_remove = (kind_r == cht_pkg::KIND_REMOVE);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // live count tracks the occupancy bits
  `CHT_ASSERT_ALWAYS(a_count_match, occupied_r == CNT_W'($countones(used_r)))
  // insert only ever claims a free slot
  `CHT_ASSERT_IMPLY(a_ins_free, cmd.ins_wr, !used_r[free_slot_r])
  // remove only ever frees a slot on a chain
  `CHT_ASSERT_IMPLY(a_rm_used, cmd.rm_wr, used_r[cur_r] && link_vld_r[cur_r])

endmodule
`default_nettype wire

// ----- hw/rtl/chained_hash_id_slot_table_top.sv -----
// top level of the chained hash id to slot table
// Maps 31-bit ids to slots of a 64-entry pool through 64 buckets selected by the low id
// bits, each bucket heading a linked chain held in link and key memories. One transaction
// is worked at a time. Insert claims the lowest free slot, which comes from a two-level
// registered search over the occupancy bits. Remove and find walk the bucket's chain
// from its head until a match or the end of the chain; the chain walk reads one entry per
// cycle from the key and link memories. An unused kind goes straight to its result. A
// finished result waits in an output register, so the next transaction can be accepted
// while out_stall holds the previous one. No clearing pass follows reset: bucket heads
// and links carry per-entry valid bits.
`default_nettype none
module chained_hash_id_slot_table_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire cht_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output cht_pkg::out_t     out_data
);

  cht_pkg::cmd_t cmd;
  cht_pkg::sts_t sts;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- verif/tb_chained_hash_id_slot_table_top.sv -----
// testbench of the chained hash id to slot table: directed and random lookups against a predictor
`default_nettype none
module tb_chained_hash_id_slot_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS   = cht_pkg::SLOTS;
  localparam int BUCKETS = cht_pkg::BUCKETS;
  localparam int KEY_W   = cht_pkg::KEY_W;
  localparam int SLOT_W  = cht_pkg::SLOT_W;
  localparam int CNT_W   = cht_pkg::CNT_W;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NIL = SLOTS;
  localparam int MAX_SHOWN = 10;

  typedef logic [KEY_W-1:0] key_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cht_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cht_pkg::out_t out_data;

  chained_hash_id_slot_table_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table
  key_t tbl_key [SLOTS];
  bit tbl_used [SLOTS];
  int tbl_link [SLOTS];
  int tbl_head [BUCKETS];
  int tbl_count;

  cht_pkg::out_t pending_results [$];
  int fail_count = 0;
  int burst_left = 0;
  key_t key_pool [16];
  int hot_bucket [4];

  function automatic void table_clear();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i] = '0;
      tbl_used[i] = 1'b0;
      tbl_link[i] = NIL;
    end
    for (int b = 0; b < BUCKETS; b++) tbl_head[b] = NIL;
    tbl_count = 0;
  endfunction

  // apply one operation to the shadow table and return its answer
  function automatic cht_pkg::out_t table_apply(cht_pkg::in_t op);
    cht_pkg::out_t res;
    int b;
    int cur;
    int prv;
    int steps;
    int i;
    res = '0;
    b = int'(op.key_id) & (BUCKETS - 1);
    case (op.kind)
      cht_pkg::KIND_INSERT: begin
        i = 0;
        while (i < SLOTS && tbl_used[i]) i++;
        if (i < SLOTS) begin
          tbl_key[i] = op.key_id;
          tbl_used[i] = 1'b1;
          tbl_link[i] = tbl_head[b];
          tbl_head[b] = i;
          tbl_count++;
          res.ok = 1'b1;
          res.slot = i[SLOT_W-1:0];
        end
      end
      cht_pkg::KIND_REMOVE, cht_pkg::KIND_FIND: begin
        // walk the chain to the newest matching entry
        cur = tbl_head[b];
        prv = NIL;
        steps = 0;
        while (cur < SLOTS && steps < SLOTS && tbl_key[cur] != op.key_id) begin
          prv = cur;
          cur = tbl_link[cur];
          steps++;
        end
        if (cur < SLOTS && steps < SLOTS) begin
          res.ok = 1'b1;
          res.slot = cur[SLOT_W-1:0];
          if (op.kind == cht_pkg::KIND_REMOVE) begin
            if (prv == NIL) tbl_head[b] = tbl_link[cur];
            else tbl_link[prv] = tbl_link[cur];
            tbl_link[cur] = NIL;
            tbl_used[cur] = 1'b0;
            if (tbl_count > 0) tbl_count--;
          end
        end
      end
      default: ;
    endcase
    res.live_count = tbl_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic cht_pkg::in_t make_op(logic [1:0] kind, key_t key);
    cht_pkg::in_t op;
    op.kind = kind;
    op.key_id = key;
    return op;
  endfunction

  task automatic log_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("mismatch: %s", msg);
  endtask

  // send one transaction, idling between bursts
  task automatic send_item(cht_pkg::in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(table_apply(item));
  endtask

  // hold the sender until every pending result has arrived
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  // receiver stall pattern: quiet, sparse, periodic or heavy stretches
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_left % 5) < 2);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // compare each result with the oldest prediction
  cht_pkg::out_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result ok %0d slot %0d count %0d",
                               out_data.ok, out_data.slot, out_data.live_count));
      end else begin
        want = pending_results.pop_front();
        if (out_data.ok !== want.ok || out_data.slot !== want.slot ||
            out_data.live_count !== want.live_count) begin
          log_mismatch($sformatf(
            "expected ok %0d slot %0d count %0d, got ok %0d slot %0d count %0d",
            want.ok, want.slot, want.live_count,
            out_data.ok, out_data.slot, out_data.live_count));
        end
      end
    end
  end

  // key source: mostly a small pool clustered on a few buckets
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return key_pool[$urandom_range(0, 15)];
    if (r < 85) return key_t'(($urandom() & 32'h7FFF_FFC0) | hot_bucket[$urandom_range(0, 3)]);
    return key_t'($urandom());
  endfunction

  function automatic void refresh_key_pool();
    for (int h = 0; h < 4; h++) hot_bucket[h] = $urandom_range(0, BUCKETS - 1);
    for (int i = 0; i < 16; i++)
      key_pool[i] = key_t'(($urandom() & 32'h7FFF_FFC0) | hot_bucket[$urandom_range(0, 3)]);
  endfunction

  // extreme ids, hits, misses and the unused kind
  task automatic test_basic_ops();
    send_item(make_op(cht_pkg::KIND_INSERT, key_t'(0)));
    send_item(make_op(cht_pkg::KIND_INSERT, {KEY_W{1'b1}}));
    send_item(make_op(cht_pkg::KIND_FIND, key_t'(0)));
    send_item(make_op(cht_pkg::KIND_FIND, {KEY_W{1'b1}}));
    send_item(make_op(cht_pkg::KIND_FIND, key_t'(64)));
    send_item(make_op(cht_pkg::KIND_REMOVE, {KEY_W{1'b1}}));
    send_item(make_op(cht_pkg::KIND_FIND, {KEY_W{1'b1}}));
    send_item(make_op(cht_pkg::KIND_REMOVE, {KEY_W{1'b1}}));
    send_item(make_op(KIND_UNUSED, {KEY_W{1'b1}}));
    send_item(make_op(KIND_UNUSED, key_t'(0)));
  endtask

  // duplicate ids and removal from the head of a chain
  task automatic test_duplicates();
    send_item(make_op(cht_pkg::KIND_INSERT, key_t'(5)));
    send_item(make_op(cht_pkg::KIND_INSERT, key_t'(69)));
    send_item(make_op(cht_pkg::KIND_INSERT, key_t'(5)));
    send_item(make_op(cht_pkg::KIND_FIND, key_t'(5)));
    send_item(make_op(cht_pkg::KIND_REMOVE, key_t'(5)));
    send_item(make_op(cht_pkg::KIND_FIND, key_t'(5)));
    send_item(make_op(cht_pkg::KIND_REMOVE, key_t'(69)));
    send_item(make_op(cht_pkg::KIND_REMOVE, key_t'(5)));
    send_item(make_op(cht_pkg::KIND_REMOVE, key_t'(0)));
    send_item(make_op(cht_pkg::KIND_FIND, key_t'(5)));
  endtask

  // fill every slot, then insert into a full pool
  task automatic test_pool_full();
    refresh_key_pool();
    for (int i = 0; i < SLOTS + 3; i++) send_item(make_op(cht_pkg::KIND_INSERT, pick_key()));
    send_item(make_op(KIND_UNUSED, pick_key()));
    send_item(make_op(cht_pkg::KIND_FIND, key_pool[0]));
  endtask

  // random mix with given weights in percent, the remainder unused kind
  task automatic test_random_mix(int count, int ins_w, int rm_w, int find_w);
    int r;
    logic [1:0] kind;
    refresh_key_pool();
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) kind = cht_pkg::KIND_INSERT;
      else if (r < ins_w + rm_w) kind = cht_pkg::KIND_REMOVE;
      else if (r < ins_w + rm_w + find_w) kind = cht_pkg::KIND_FIND;
      else kind = KIND_UNUSED;
      send_item(make_op(kind, pick_key()));
    end
  endtask

  initial begin
    table_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_duplicates();
    test_pool_full();
    test_random_mix(300, 20, 55, 22);
    test_random_mix(300, 70, 15, 12);
    test_random_mix(300, 40, 30, 25);
    wait_results_drained();
    test_random_mix(300, 60, 20, 15);
    test_random_mix(300, 35, 35, 25);
    test_random_mix(300, 10, 70, 17);
    wait_results_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cht_pkg.sv
hw/rtl/cht_ram.sv
hw/rtl/cht_ctrl.sv
hw/rtl/cht_dp.sv
hw/rtl/chained_hash_id_slot_table_top.sv
verif/tb_chained_hash_id_slot_table_top.sv
